@@ hw/rtl/i2cms_pkg.sv @@
// Package for the I2C master transaction sequencer.
// Holds word types, operation, phase and status codes, and sizing constants.
// No dependencies.
package i2cms_pkg;

    localparam int I2CMS_MAX_BYTES = 16;
    localparam int BUF_DEPTH       = 16;
    localparam int BUF_AW          = 4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic [2:0] FUNC_LOAD  = 3'd0;
    localparam logic [2:0] FUNC_READ  = 3'd1;
    localparam logic [2:0] FUNC_WRITE = 3'd2;
    localparam logic [2:0] FUNC_EVENT = 3'd3;
    localparam logic [2:0] FUNC_TICK  = 3'd4;
    localparam logic [2:0] FUNC_QUERY = 3'd5;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_DONE = 3'd1;
    localparam logic [2:0] PH_ERR  = 3'd2;
    localparam logic [2:0] PH_RX   = 3'd3;
    localparam logic [2:0] PH_ADDR = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_DEV  = 3'd6;

    localparam logic [1:0] ST_SUCCESS = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    localparam int CB_MST = 0;
    localparam int CB_TX  = 1;
    localparam int CB_NAK = 2;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  byte_index;
        logic [7:0]  data_byte;
        logic [7:0]  device;
        logic [7:0]  reg_address;
        logic [7:0]  length;
        logic        tcf;
        logic        rxak;
        logic        arbl;
        logic [15:0] period_ms;
    } i2cms_in_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] status_code;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       master_on;
        logic       transmit_on;
        logic       no_ack;
        logic       discard_read;
    } i2cms_out_t;

endpackage

@@ hw/rtl/i2cms_core.sv @@
// Transaction state, write buffer and per-word next-state logic.
// Depends on i2cms_pkg.
module i2cms_core
    import i2cms_pkg::*;
#(
    parameter int MAX_BYTES = I2CMS_MAX_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] timeout_limit,
    input  logic        step_en,
    input  i2cms_in_t   item,
    output i2cms_out_t  result
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_BYTES);

    logic [2:0]        phase_reg,   phase_next;
    logic [7:0]        device_reg,  device_next;
    logic [7:0]        address_reg, address_next;
    logic [7:0]        left_reg,    left_next;
    logic [BUF_AW-1:0] wptr_reg,    wptr_next;
    logic [15:0]       time_reg,    time_next;
    logic [2:0]        cb_reg,      cb_next;
    logic [7:0]        wbuf_reg [BUF_DEPTH];

    logic busy;

    assign busy = (phase_reg >= PH_RX) && (phase_reg <= PH_DEV);

    always_comb begin
        phase_next   = phase_reg;
        device_next  = device_reg;
        address_next = address_reg;
        left_next    = left_reg;
        wptr_next    = wptr_reg;
        time_next    = time_reg;
        cb_next      = cb_reg;
        result       = '0;

        unique case (item.func) inside
            FUNC_READ, FUNC_WRITE: begin
                if (item.func == FUNC_READ) begin
                    device_next = item.device | 8'h01;
                    left_next   = item.length;
                end else begin
                    address_next = item.reg_address;
                    device_next  = item.device;
                    left_next    = (item.length > MAX_LEN) ? MAX_LEN : item.length;
                    wptr_next    = '0;
                end
                cb_next         = 3'b111;
                phase_next      = PH_DEV;
                time_next       = timeout_limit;
                result.tx_valid = 1'b1;
                result.tx_byte  = device_next;
            end
            FUNC_EVENT: begin
                if (item.arbl) begin
                    result.discard_read = 1'b1;
                    if (phase_reg != PH_IDLE) begin
                        cb_next    = '0;
                        phase_next = PH_ERR;
                        time_next  = '0;
                    end
                end else if (!item.tcf) begin
                    cb_next    = '0;
                    phase_next = PH_ERR;
                    time_next  = '0;
                end else begin
                    case (phase_reg) inside
                        PH_RX: begin
                            result.rx_valid = 1'b1;
                            result.rx_byte  = item.data_byte;
                            if (left_reg <= 8'd1) begin
                                cb_next         = cb_reg | 3'b100;
                                cb_next[CB_MST] = 1'b0;
                                cb_next[CB_TX]  = 1'b0;
                                left_next       = '0;
                                result.rx_last  = 1'b1;
                                phase_next      = PH_DONE;
                                time_next       = '0;
                            end else begin
                                left_next = left_reg - 8'd1;
                            end
                        end
                        PH_ADDR, PH_DATA: begin
                            phase_next = PH_DATA;
                            if (item.rxak) begin
                                cb_next    = '0;
                                phase_next = PH_ERR;
                                time_next  = '0;
                            end else if (left_reg != 8'd0) begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = wbuf_reg[wptr_reg];
                                wptr_next       = wptr_reg + BUF_AW'(1);
                                left_next       = left_reg - 8'd1;
                            end else begin
                                cb_next[CB_MST] = 1'b0;
                                cb_next[CB_TX]  = 1'b0;
                                phase_next      = PH_DONE;
                                time_next       = '0;
                            end
                        end
                        PH_DEV: begin
                            if (item.rxak) begin
                                cb_next    = '0;
                                phase_next = PH_ERR;
                                time_next  = '0;
                            end else if (!device_reg[0]) begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = address_reg;
                                phase_next      = PH_ADDR;
                            end else begin
                                cb_next[CB_TX]      = 1'b0;
                                cb_next[CB_NAK]     = 1'b0;
                                result.discard_read = 1'b1;
                                phase_next          = PH_RX;
                            end
                        end
                        default: begin
                            result.discard_read = 1'b1;
                        end
                    endcase
                end
            end
            FUNC_TICK: begin
                if (busy) begin
                    if (time_reg <= item.period_ms) begin
                        cb_next    = '0;
                        phase_next = PH_ERR;
                        time_next  = '0;
                    end else begin
                        time_next = time_reg - item.period_ms;
                    end
                end
            end
            FUNC_QUERY: begin
                if (phase_reg == PH_DONE) begin
                    result.status_code = ST_SUCCESS;
                    phase_next         = PH_IDLE;
                end else if (phase_reg == PH_ERR) begin
                    result.status_code = ST_ERROR;
                    phase_next         = PH_IDLE;
                end else if (busy) begin
                    result.status_code = ST_PENDING;
                end else begin
                    result.status_code = ST_ERROR;
                end
            end
            default: begin
            end
        endcase

        result.phase       = phase_next;
        result.master_on   = cb_next[CB_MST];
        result.transmit_on = cb_next[CB_TX];
        result.no_ack      = cb_next[CB_NAK];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            device_reg  <= '0;
            address_reg <= '0;
            left_reg    <= '0;
            wptr_reg    <= '0;
            time_reg    <= '0;
            cb_reg      <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            device_reg  <= device_next;
            address_reg <= address_next;
            left_reg    <= left_next;
            wptr_reg    <= wptr_next;
            time_reg    <= time_next;
            cb_reg      <= cb_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && item.func == FUNC_LOAD) begin
            wbuf_reg[item.byte_index] <= item.data_byte;
        end
    end

endmodule

@@ hw/rtl/i2c_master_transaction_sequencer_unit.sv @@
// The result word of an accepted word is held in the input register, then in the result
// register, where it sits on m_word with m_valid high.
// Throughput: one word per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous): idle phase, control bits clear, timeout 100,
// both registers empty. Write buffer contents are undefined until loaded.
module i2c_master_transaction_sequencer_unit
    import i2cms_pkg::*;
#(
    parameter int MAX_BYTES = I2CMS_MAX_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  i2cms_in_t   s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output i2cms_out_t  m_word
);

    logic [15:0] timeout_reg;
    logic        in_vld_reg;
    i2cms_in_t   in_reg;
    logic        out_vld_reg;
    i2cms_out_t  out_reg;
    i2cms_out_t  result;
    logic        advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_word  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    i2cms_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .timeout_limit (timeout_reg),
        .step_en       (advance),
        .item          (in_reg),
        .result        (result)
    );

    a_pending_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status_code == ST_PENDING |->
            m_word.phase >= PH_RX && m_word.phase <= PH_DEV)
        else $error("pending reported outside a busy phase");

    a_tx_master: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.tx_valid |-> m_word.master_on && m_word.transmit_on)
        else $error("byte sent without master transmit mode");

    a_rx_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.rx_last |->
            m_word.phase == PH_DONE && !m_word.master_on && m_word.no_ack)
        else $error("last read byte without completion");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld_reg && out_vld_reg && !m_ready)
        else $error("input stalled while the pipeline can move");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_transaction_sequencer_unit.
// Predicts every result word with a scoreboard class; depends on i2cms_pkg and the unit.
module tb_top;
    import i2cms_pkg::*;

    class i2c_txn_scoreboard;
        logic [15:0] timeout_limit;
        logic [2:0]  phase;
        logic [7:0]  dev_byte;
        logic [7:0]  addr_byte;
        logic [7:0]  bytes_left;
        logic [3:0]  wr_ptr;
        logic [15:0] time_left;
        logic [7:0]  wr_buf [BUF_DEPTH];
        logic [2:0]  ctrl;
        i2cms_out_t  nxt;
        i2cms_out_t  pending_results[$];
        int          errors;
        int          words_checked;

        function new();
            timeout_limit = TIMEOUT_RESET;
            phase         = PH_IDLE;
            dev_byte      = '0;
            addr_byte     = '0;
            bytes_left    = '0;
            wr_ptr        = '0;
            time_left     = '0;
            ctrl          = '0;
            errors        = 0;
            words_checked = 0;
        endfunction

        function void to_error();
            ctrl      = '0;
            phase     = PH_ERR;
            time_left = '0;
        endfunction

        function void to_done();
            ctrl[CB_MST] = 1'b0;
            ctrl[CB_TX]  = 1'b0;
            phase        = PH_DONE;
            time_left    = '0;
        endfunction

        function void begin_tx();
            ctrl[CB_MST] = 1'b1;
            ctrl[CB_TX]  = 1'b1;
            ctrl[CB_NAK] = 1'b1;
            phase        = PH_DEV;
            time_left    = timeout_limit;
            nxt.tx_valid = 1'b1;
            nxt.tx_byte  = dev_byte;
        endfunction

        function bit busy();
            return phase >= PH_RX && phase <= PH_DEV;
        endfunction

        function void note_word(i2cms_in_t w);
            nxt = '0;
            case (w.func)
                FUNC_LOAD: begin
                    wr_buf[w.byte_index] = w.data_byte;
                end
                FUNC_READ: begin
                    dev_byte   = w.device | 8'h01;
                    bytes_left = w.length;
                    begin_tx();
                end
                FUNC_WRITE: begin
                    addr_byte  = w.reg_address;
                    dev_byte   = w.device;
                    bytes_left = (w.length > I2CMS_MAX_BYTES) ? 8'(I2CMS_MAX_BYTES) : w.length;
                    wr_ptr     = '0;
                    begin_tx();
                end
                FUNC_EVENT: begin
                    if (w.arbl) begin
                        nxt.discard_read = 1'b1;
                        if (phase != PH_IDLE) to_error();
                    end else if (!w.tcf) begin
                        to_error();
                    end else begin
                        case (phase)
                            PH_RX: begin
                                nxt.rx_valid = 1'b1;
                                nxt.rx_byte  = w.data_byte;
                                if (bytes_left <= 8'd1) begin
                                    ctrl[CB_NAK] = 1'b1;
                                    bytes_left   = '0;
                                    nxt.rx_last  = 1'b1;
                                    to_done();
                                end else begin
                                    bytes_left = bytes_left - 8'd1;
                                end
                            end
                            PH_ADDR, PH_DATA: begin
                                phase = PH_DATA;
                                if (w.rxak) begin
                                    to_error();
                                end else if (bytes_left > 0) begin
                                    nxt.tx_valid = 1'b1;
                                    nxt.tx_byte  = wr_buf[wr_ptr];
                                    wr_ptr       = wr_ptr + 4'd1;
                                    bytes_left   = bytes_left - 8'd1;
                                end else begin
                                    to_done();
                                end
                            end
                            PH_DEV: begin
                                if (w.rxak) begin
                                    to_error();
                                end else if (!dev_byte[0]) begin
                                    nxt.tx_valid = 1'b1;
                                    nxt.tx_byte  = addr_byte;
                                    phase        = PH_ADDR;
                                end else begin
                                    ctrl[CB_TX]      = 1'b0;
                                    ctrl[CB_NAK]     = 1'b0;
                                    nxt.discard_read = 1'b1;
                                    phase            = PH_RX;
                                end
                            end
                            default: begin
                                nxt.discard_read = 1'b1;
                            end
                        endcase
                    end
                end
                FUNC_TICK: begin
                    if (busy()) begin
                        if (time_left <= w.period_ms) to_error();
                        else time_left = time_left - w.period_ms;
                    end
                end
                FUNC_QUERY: begin
                    if (phase == PH_DONE) begin
                        nxt.status_code = ST_SUCCESS;
                        phase           = PH_IDLE;
                    end else if (phase == PH_ERR) begin
                        nxt.status_code = ST_ERROR;
                        phase           = PH_IDLE;
                    end else if (busy()) begin
                        nxt.status_code = ST_PENDING;
                    end else begin
                        nxt.status_code = ST_ERROR;
                    end
                end
                default: begin
                end
            endcase
            nxt.phase       = phase;
            nxt.master_on   = ctrl[CB_MST];
            nxt.transmit_on = ctrl[CB_TX];
            nxt.no_ack      = ctrl[CB_NAK];
            pending_results.push_back(nxt);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH word %0d %s: got 0x%0h want 0x%0h",
                     words_checked, what, got, want);
            errors++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report_mismatch(name, int'(got), int'(want));
        endtask

        task check_word(i2cms_out_t got);
            i2cms_out_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", int'(got), 0);
            end else begin
                want = pending_results.pop_front();
                check_field("phase", 8'(got.phase), 8'(want.phase));
                check_field("status_code", 8'(got.status_code), 8'(want.status_code));
                check_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
                check_field("tx_byte", got.tx_byte, want.tx_byte);
                check_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
                check_field("rx_byte", got.rx_byte, want.rx_byte);
                check_field("rx_last", 8'(got.rx_last), 8'(want.rx_last));
                check_field("master_on", 8'(got.master_on), 8'(want.master_on));
                check_field("transmit_on", 8'(got.transmit_on), 8'(want.transmit_on));
                check_field("no_ack", 8'(got.no_ack), 8'(want.no_ack));
                check_field("discard_read", 8'(got.discard_read), 8'(want.discard_read));
            end
            words_checked++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    i2cms_in_t   s_word;
    logic        m_valid;
    logic        m_ready = 1'b0;
    i2cms_out_t  m_word;

    i2c_txn_scoreboard sb;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int stall_left = 0;
    int sent_items = 0;

    i2c_master_transaction_sequencer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    initial begin
        #1_200_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int pick_idle(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic i2cms_in_t op_word(logic [2:0] f);
        logic [63:0] raw;
        i2cms_in_t   w;
        raw    = {$urandom(), $urandom()};
        w      = raw[$bits(i2cms_in_t)-1:0];
        w.func = f;
        return w;
    endfunction

    function automatic i2cms_in_t ev_word(bit tcf, bit rxak, bit arbl, logic [7:0] data);
        i2cms_in_t w;
        w           = op_word(FUNC_EVENT);
        w.tcf       = tcf;
        w.rxak      = rxak;
        w.arbl      = arbl;
        w.data_byte = data;
        return w;
    endfunction

    function automatic i2cms_in_t start_word(logic [2:0] f, logic [7:0] dev,
                                             logic [7:0] addr, logic [7:0] len);
        i2cms_in_t w;
        w             = op_word(f);
        w.device      = dev;
        w.reg_address = addr;
        w.length      = len;
        return w;
    endfunction

    function automatic i2cms_in_t tick_word(logic [15:0] period);
        i2cms_in_t w;
        w           = op_word(FUNC_TICK);
        w.period_ms = period;
        return w;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_word);
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            stall_left = pick_idle(rx_idle_on);
            m_ready <= (stall_left == 0);
        end
    end

    task automatic send_word(input i2cms_in_t w);
        int gap;
        gap = pick_idle(tx_idle_on);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(w);
        sent_items++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_timeout(logic [15:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.timeout_limit = value;
    endtask

    task automatic maybe_interject();
        if (chance(12))
            send_word(tick_word(chance(85) ? 16'($urandom_range(0, 30))
                                           : 16'($urandom_range(0, 65535))));
        if (chance(8)) send_word(op_word(FUNC_QUERY));
    endtask

    task automatic random_event();
        send_word(ev_word(!chance(3), chance(3), chance(2), 8'($urandom)));
    endtask

    task automatic random_write();
        i2cms_in_t   w;
        logic [7:0]  dev;
        int          len;
        int          n_ev;
        repeat ($urandom_range(0, 3)) send_word(op_word(FUNC_LOAD));
        len = chance(90) ? $urandom_range(0, 20) : $urandom_range(0, 255);
        dev = 8'($urandom);
        if (chance(90)) dev[0] = 1'b0;
        w = start_word(FUNC_WRITE, dev, 8'($urandom), 8'(len));
        send_word(w);
        n_ev = ((len > I2CMS_MAX_BYTES) ? I2CMS_MAX_BYTES : len) + 2 + $urandom_range(0, 1);
        repeat (n_ev) begin
            maybe_interject();
            random_event();
        end
        send_word(op_word(FUNC_QUERY));
        if (chance(30)) send_word(op_word(FUNC_QUERY));
    endtask

    task automatic random_read();
        int len;
        int n_ev;
        len = chance(90) ? $urandom_range(0, 8) : $urandom_range(0, 255);
        send_word(start_word(FUNC_READ, 8'($urandom), 8'($urandom), 8'(len)));
        n_ev = ((len > 10) ? 10 : len) + 1 + $urandom_range(0, 1);
        repeat (n_ev) begin
            maybe_interject();
            random_event();
        end
        send_word(op_word(FUNC_QUERY));
    endtask

    task automatic random_noise();
        repeat ($urandom_range(1, 6)) send_word(op_word(3'($urandom_range(0, 7))));
    endtask

    task automatic directed_words();
        i2cms_in_t w;
        for (int i = 0; i < BUF_DEPTH; i++) begin
            w            = op_word(FUNC_LOAD);
            w.byte_index = 4'(i);
            w.data_byte  = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
            send_word(w);
        end
        send_word(op_word(FUNC_QUERY));
        send_word(ev_word(1'b1, 1'b0, 1'b0, 8'h00));
        send_word(ev_word(1'b1, 1'b0, 1'b1, 8'h00));
        send_word(ev_word(1'b0, 1'b0, 1'b0, 8'h00));
        send_word(op_word(FUNC_QUERY));
        send_word(start_word(FUNC_WRITE, 8'hA0, 8'hFF, 8'hFF));
        send_word(ev_word(1'b1, 1'b0, 1'b0, 8'h00));
        send_word(op_word(FUNC_QUERY));
        send_word(ev_word(1'b1, 1'b0, 1'b0, 8'h00));
        send_word(op_word(FUNC_QUERY));
        send_word(start_word(FUNC_READ, 8'h00, 8'h00, 8'h00));
        send_word(ev_word(1'b1, 1'b0, 1'b0, 8'h00));
        send_word(ev_word(1'b1, 1'b0, 1'b0, 8'hFF));
        send_word(op_word(FUNC_QUERY));
        send_word(start_word(FUNC_WRITE, 8'h51, 8'h00, 8'h01));
        send_word(ev_word(1'b1, 1'b0, 1'b0, 8'h00));
        send_word(tick_word(16'h0000));
        send_word(tick_word(16'hFFFF));
        send_word(op_word(FUNC_QUERY));
        send_word(start_word(FUNC_WRITE, 8'hFE, 8'h00, 8'h00));
        send_word(ev_word(1'b1, 1'b0, 1'b0, 8'h00));
        send_word(ev_word(1'b1, 1'b0, 1'b0, 8'h00));
        send_word(op_word(FUNC_QUERY));
        send_word(start_word(FUNC_WRITE, 8'h00, 8'h00, 8'h02));
        send_word(ev_word(1'b1, 1'b1, 1'b0, 8'h00));
        send_word(op_word(3'd6));
        send_word(op_word(3'd7));
    endtask

    initial begin
        logic [15:0] timeouts [4];
        int          target;
        sb          = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_word      = '0;
        timeouts    = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 65534)), TIMEOUT_RESET};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        directed_words();
        foreach (timeouts[p]) begin
            program_timeout(timeouts[p]);
            target = sent_items + 375;
            while (sent_items < target) begin
                tx_idle_on = chance(75);
                rx_idle_on = chance(75);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: random_write();
                    4, 5, 6, 7: random_read();
                    default:    random_noise();
                endcase
            end
        end
        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_core.sv
hw/rtl/i2c_master_transaction_sequencer_unit.sv
tb/tb_top.sv
